// ===== sv/sdt_pkg.sv =====
// Shared types and constants for the strongest device table.
`default_nettype none

package sdt_pkg;

    localparam int ADDR_W   = 48;
    localparam int STR_W    = 8;
    localparam int OP_W     = 2;
    localparam int RIDX_W   = 6;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 7;
    localparam int ENTRY_W  = ADDR_W + STR_W;

    localparam logic [OP_W-1:0] OP_ADVERT = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd6;

    localparam logic signed [STR_W-1:0] EMPTY_STRENGTH = -8'sd127;

    typedef struct packed {
        logic load;        // take the input item
        logic scan;        // walk the table
        logic plan;        // pick source and target positions
        logic move;        // read next shifted entry or write the new one
        logic move_wr;     // write the shifted entry
        logic read_issue;  // read the requested entry
        logic finish;      // load the result register
    } t_sdt_cmd;

    typedef struct packed {
        logic start_scan;
        logic start_read;
        logic scan_done;
        logic drop;
        logic at_target;
        logic out_free;
    } t_sdt_stat;

endpackage

`default_nettype wire

// ===== sv/strongest_device_table_unit.sv =====
// Top level of the strongest device table: controller plus datapath.
// Keeps up to TABLE_DEPTH devices (48-bit address, signed dBm strength) in one
// RAM, ordered by descending strength with ties in arrival order. One item is
// worked at a time; o_in_stall is high from acceptance until its result is
// loaded into the output register, and the next item may be taken while that
// result still waits. An advertisement with an address is worked in steps: the
// single RAM read port walks all entries present before the item once, then
// every shifted entry takes one read and one write, and the changed entry is
// written at its new position. A dropped advertisement skips the reorder; a
// read issues a single RAM read, and a clear or an ignored item goes straight
// to the result. No clearing pass after reset.
`default_nettype none

module strongest_device_table_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic [sdt_pkg::OP_W-1:0]             i_operation,
    input  wire logic                                 i_has_address,
    input  wire logic [sdt_pkg::ADDR_W-1:0]           i_device_address,
    input  wire logic signed [sdt_pkg::STR_W-1:0]     i_signal_strength,
    input  wire logic [sdt_pkg::RIDX_W-1:0]           i_read_index,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic [sdt_pkg::STATUS_W-1:0]              o_status,
    output logic [sdt_pkg::TOTAL_W-1:0]               o_entry_total,
    output logic signed [sdt_pkg::STR_W-1:0]          o_best_strength,
    output logic [sdt_pkg::ADDR_W-1:0]                o_read_address,
    output logic signed [sdt_pkg::STR_W-1:0]          o_read_strength
);

    sdt_pkg::t_sdt_cmd  cmd;
    sdt_pkg::t_sdt_stat stat;

    sdt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    sdt_datapath #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_operation      (i_operation),
        .i_has_address    (i_has_address),
        .i_device_address (i_device_address),
        .i_signal_strength(i_signal_strength),
        .i_read_index     (i_read_index),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_entry_total    (o_entry_total),
        .o_best_strength  (o_best_strength),
        .o_read_address   (o_read_address),
        .o_read_strength  (o_read_strength)
    );

endmodule

`default_nettype wire

// ===== sv/sdt_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module sdt_ram #(
    parameter int WIDTH  = 56,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/sdt_ctrl.sv =====
// Sequencer for scan, reorder, read and result hand-off.
`default_nettype none

module sdt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire sdt_pkg::t_sdt_stat i_stat,
    output sdt_pkg::t_sdt_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_PLAN    = 3'd2;
    localparam logic [2:0] S_MOVE    = 3'd3;
    localparam logic [2:0] S_MOVE_WR = 3'd4;
    localparam logic [2:0] S_READ    = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = accept;
        o_cmd.scan       = (r_state == S_SCAN);
        o_cmd.plan       = (r_state == S_PLAN);
        o_cmd.move       = (r_state == S_MOVE);
        o_cmd.move_wr    = (r_state == S_MOVE_WR);
        o_cmd.read_issue = (r_state == S_READ);
        o_cmd.finish     = (r_state == S_DONE) && i_stat.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_stat.start_scan) begin
                        n_state = S_SCAN;
                    end else if (i_stat.start_read) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                n_state = i_stat.drop ? S_DONE : S_MOVE;
            end
            S_MOVE: begin
                n_state = i_stat.at_target ? S_DONE : S_MOVE_WR;
            end
            S_MOVE_WR: begin
                n_state = S_MOVE;
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sdt_datapath.sv =====
// Table storage, scan accumulators, reorder pointers and result register.
`default_nettype none

module sdt_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire sdt_pkg::t_sdt_cmd                    i_cmd,
    output sdt_pkg::t_sdt_stat                        o_stat,
    input  wire logic [sdt_pkg::OP_W-1:0]             i_operation,
    input  wire logic                                 i_has_address,
    input  wire logic [sdt_pkg::ADDR_W-1:0]           i_device_address,
    input  wire logic signed [sdt_pkg::STR_W-1:0]     i_signal_strength,
    input  wire logic [sdt_pkg::RIDX_W-1:0]           i_read_index,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic [sdt_pkg::STATUS_W-1:0]              o_status,
    output logic [sdt_pkg::TOTAL_W-1:0]               o_entry_total,
    output logic signed [sdt_pkg::STR_W-1:0]          o_best_strength,
    output logic [sdt_pkg::ADDR_W-1:0]                o_read_address,
    output logic signed [sdt_pkg::STR_W-1:0]          o_read_strength
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // latched item
    logic [sdt_pkg::ADDR_W-1:0]       r_addr;
    logic signed [sdt_pkg::STR_W-1:0] r_str;
    logic [sdt_pkg::RIDX_W-1:0]       r_ridx;
    logic [sdt_pkg::STATUS_W-1:0]     r_status;

    // table state
    logic [CNT_W-1:0]                 r_count;
    logic signed [sdt_pkg::STR_W-1:0] r_best;

    // scan
    logic [CNT_W-1:0]                 r_idx;
    logic                             r_pend;
    logic [IDX_W-1:0]                 r_chk_idx;
    logic                             r_found;
    logic [IDX_W-1:0]                 r_pos;
    logic [CNT_W-1:0]                 r_gt;
    logic [CNT_W-1:0]                 r_eq;
    logic signed [sdt_pkg::STR_W-1:0] r_min;
    logic [IDX_W-1:0]                 r_wk;

    // reorder
    logic [IDX_W-1:0]                 r_k;
    logic [IDX_W-1:0]                 r_j;
    logic                             r_down;
    logic                             r_rd_hit;

    // result register
    logic                             r_out_valid;
    logic [sdt_pkg::STATUS_W-1:0]     r_o_status;
    logic [sdt_pkg::TOTAL_W-1:0]      r_o_total;
    logic signed [sdt_pkg::STR_W-1:0] r_o_best;
    logic [sdt_pkg::ADDR_W-1:0]       r_o_raddr;
    logic signed [sdt_pkg::STR_W-1:0] r_o_rstr;

    // RAM ports
    logic                             wr_en;
    logic [IDX_W-1:0]                 wr_addr;
    logic [sdt_pkg::ENTRY_W-1:0]      wr_data;
    logic                             rd_en;
    logic [IDX_W-1:0]                 rd_addr;
    logic [sdt_pkg::ENTRY_W-1:0]      ram_q;

    logic [sdt_pkg::ADDR_W-1:0]       q_addr;
    logic signed [sdt_pkg::STR_W-1:0] q_str;
    logic                             issue;
    logic                             table_full;
    logic                             beats_min;
    logic [CNT_W:0]                   k_sum;
    logic [IDX_W-1:0]                 k_pos;
    logic [IDX_W-1:0]                 p_pos;
    logic [IDX_W-1:0]                 src;
    logic                             at_target;
    logic                             out_free;
    logic                             read_hit;

    sdt_ram #(
        .WIDTH (sdt_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .ADDR_W(IDX_W)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(ram_q)
    );

    assign q_addr     = ram_q[sdt_pkg::ENTRY_W-1:sdt_pkg::STR_W];
    assign q_str      = ram_q[sdt_pkg::STR_W-1:0];
    assign issue      = i_cmd.scan && (r_idx < r_count);
    assign table_full = (r_count == CNT_W'(TABLE_DEPTH));
    assign beats_min  = (r_str > r_min);
    assign k_sum      = {1'b0, r_gt} + {1'b0, r_eq};
    assign k_pos      = k_sum[IDX_W-1:0];
    assign at_target  = (r_j == r_k);
    assign src        = r_down ? (r_j - IDX_W'(1)) : (r_j + IDX_W'(1));
    assign out_free   = !r_out_valid || !i_out_stall;
    assign read_hit   = ({1'b0, r_ridx} < sdt_pkg::TOTAL_W'(r_count));

    always_comb begin
        if (r_found) begin
            p_pos = r_pos;
        end else if (!table_full) begin
            p_pos = r_count[IDX_W-1:0];
        end else begin
            p_pos = r_wk;
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.start_scan = (i_operation == sdt_pkg::OP_ADVERT) && i_has_address;
        o_stat.start_read = (i_operation == sdt_pkg::OP_READ);
        o_stat.scan_done  = !(r_idx < r_count) && !r_pend;
        o_stat.drop       = !r_found && table_full && !beats_min;
        o_stat.at_target  = at_target;
        o_stat.out_free   = out_free;
    end

    // one read port shared by scan, shift and entry read
    always_comb begin
        rd_en   = issue || (i_cmd.move && !at_target) || i_cmd.read_issue;
        rd_addr = r_ridx[IDX_W-1:0];
        if (i_cmd.scan) begin
            rd_addr = r_idx[IDX_W-1:0];
        end else if (i_cmd.move) begin
            rd_addr = src;
        end
    end

    always_comb begin
        wr_en   = (i_cmd.move && at_target) || i_cmd.move_wr;
        wr_addr = i_cmd.move_wr ? r_j : r_k;
        wr_data = i_cmd.move_wr ? ram_q : {r_addr, r_str};
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_pend <= 1'b0;
                if (i_operation == sdt_pkg::OP_CLEAR) begin
                    r_count <= '0;
                end
            end else if (i_cmd.scan) begin
                r_pend <= issue;
            end
            if (i_cmd.plan && !r_found && !table_full) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr   <= i_device_address;
            r_str    <= i_signal_strength;
            r_ridx   <= i_read_index;
            r_idx    <= '0;
            r_found  <= 1'b0;
            r_gt     <= '0;
            r_eq     <= '0;
            r_rd_hit <= 1'b0;
            case (i_operation)
                sdt_pkg::OP_ADVERT: r_status <= sdt_pkg::ST_IGNORED;
                sdt_pkg::OP_CLEAR:  r_status <= sdt_pkg::ST_CLEARED;
                sdt_pkg::OP_READ:   r_status <= sdt_pkg::ST_READ_OK;
                default:            r_status <= sdt_pkg::ST_IGNORED;
            endcase
        end

        if (issue) begin
            r_idx     <= r_idx + CNT_W'(1);
            r_chk_idx <= r_idx[IDX_W-1:0];
        end

        // evaluate the entry whose read was issued in the previous cycle
        if (i_cmd.scan && r_pend) begin
            if (q_addr == r_addr) begin
                r_found <= 1'b1;
                r_pos   <= r_chk_idx;
            end else begin
                if (q_str > r_str) begin
                    r_gt <= r_gt + CNT_W'(1);
                end
                if ((q_str == r_str) && !r_found) begin
                    r_eq <= r_eq + CNT_W'(1);
                end
            end
            if ((r_chk_idx == '0) || (q_str < r_min)) begin
                r_min <= q_str;
                r_wk  <= r_chk_idx;
            end
        end

        if (i_cmd.plan) begin
            r_k    <= k_pos;
            r_j    <= p_pos;
            r_down <= !(k_pos > p_pos);
            if (r_found) begin
                r_status <= sdt_pkg::ST_UPDATED;
            end else if (!table_full) begin
                r_status <= sdt_pkg::ST_INSERTED;
            end else if (beats_min) begin
                r_status <= sdt_pkg::ST_REPLACED;
            end else begin
                r_status <= sdt_pkg::ST_DROPPED;
            end
        end

        if (i_cmd.move_wr) begin
            r_j <= src;
        end

        if (i_cmd.read_issue) begin
            r_rd_hit <= read_hit;
        end

        // mirror entry zero for the best strength
        if (wr_en && (wr_addr == '0)) begin
            r_best <= wr_data[sdt_pkg::STR_W-1:0];
        end

        if (i_cmd.finish) begin
            r_o_status <= r_status;
            r_o_total  <= sdt_pkg::TOTAL_W'(r_count);
            r_o_best   <= (r_count != '0) ? r_best : sdt_pkg::EMPTY_STRENGTH;
            r_o_raddr  <= r_rd_hit ? q_addr : '0;
            r_o_rstr   <= r_rd_hit ? q_str : sdt_pkg::EMPTY_STRENGTH;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_entry_total   = r_o_total;
    assign o_best_strength = r_o_best;
    assign o_read_address  = r_o_raddr;
    assign o_read_strength = r_o_rstr;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (CNT_W'(wr_addr) < r_count))
        else $error("table write beyond valid entries");

    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> o_out_valid)
        else $error("finished item not presented");

endmodule

`default_nettype wire
